/* rtl/core/bmh_pkg.sv */
`timescale 1ns / 1ps

package bmh_pkg;

    // store geometry (depth is a power of two, the store is a ring)
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // field widths
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int CAP_W      = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FLOAT = CFG_IDX_W'(1);

    // reset values of the configuration registers
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(63);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_POST,
        S_EMIT
    } t_state;

    // maps a key onto an unsigned code whose order is the key order
    function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] k,
                                                    input logic              is_float);
        logic [KEY_W-1:0] sign;
        logic [KEY_W-1:0] kk;
        sign = {1'b1, {(KEY_W-1){1'b0}}};
        kk   = k;
        if (is_float) begin
            // negative zero folds onto positive zero
            if (kk == sign) begin
                kk = '0;
            end
            order_code = kk[KEY_W-1] ? ~kk : (kk | sign);
        end else begin
            order_code = kk;
        end
    endfunction

endpackage

/* rtl/core/bmh_store.sv */
`timescale 1ns / 1ps

module bmh_store (
    input  logic              i_clk,
    input  bmh_pkg::t_mem_req i_req,
    output bmh_pkg::t_entry   o_rd_data
);

    bmh_pkg::t_entry r_mem [bmh_pkg::STORE_DEPTH];
    bmh_pkg::t_entry r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/bmh_cmp.sv */
`timescale 1ns / 1ps

module bmh_cmp (
    input  logic [bmh_pkg::KEY_W-1:0] i_a,
    input  logic [bmh_pkg::KEY_W-1:0] i_b,
    input  logic                      i_is_float,
    output logic                      o_above
);

    logic [bmh_pkg::KEY_W-1:0] code_a;
    logic [bmh_pkg::KEY_W-1:0] code_b;

    // strict compare of the order codes, equal keys never move
    always_comb begin
        code_a  = bmh_pkg::order_code(i_a, i_is_float);
        code_b  = bmh_pkg::order_code(i_b, i_is_float);
        o_above = (code_a > code_b);
    end

endmodule

/* rtl/core/bounded_min_heap_merge_buffer_unit.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// s (in)    input      i_s_tvalid / o_s_tready    tdata: point_key, point_value; tlast: end_of_series
// m (out)   output     o_m_tvalid / i_m_tready    tdata: out_key, out_value; tuser: from_drain;
//                                                 tlast: run_last
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Entries sit in ascending order in a 64-entry ring memory with a registered read.
// An insert moves every held entry with a larger key one place back, one entry per cycle,
// by the read-compare-write loop, then writes the new entry into the gap.
// One transaction is worked at a time; a waiting result blocks the next emission, and input waits with it.
// Synchronous active-low reset empties the store and restores the register defaults.

module bounded_min_heap_merge_buffer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [127:0]                  i_s_tdata,   // point_key, point_value
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [127:0]                  o_m_tdata,   // out_key, out_value
    output logic                          o_m_tuser,   // from_drain
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bmh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bmh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = bmh_pkg::ADDR_W;
    localparam int CW = bmh_pkg::CNT_W;

    bmh_pkg::t_state   r_state, n_state;
    bmh_pkg::t_entry   r_new, n_new;
    logic              r_end, n_end;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic              r_drain, n_drain;
    logic [bmh_pkg::CAP_W-1:0] r_cap;
    logic              r_float;

    logic              r_m_tvalid, n_m_tvalid;
    bmh_pkg::t_entry   r_m_data, n_m_data;
    logic              r_m_drain, n_m_drain;
    logic              r_m_last, n_m_last;

    bmh_pkg::t_mem_req mem_req;
    bmh_pkg::t_entry   rd_data;
    logic              above;
    logic              s_fire;
    logic              out_free;
    logic [CW-1:0]     limit;
    logic              want_emit;
    logic              emit_last;

    bmh_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    bmh_cmp u_cmp (
        .i_a        (rd_data.key),
        .i_b        (r_new.key),
        .i_is_float (r_float),
        .o_above    (above)
    );

    // handshakes
    assign o_s_tready  = (r_state == bmh_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_tvalid || i_m_tready;

    // effective limit saturates below the store depth
    always_comb begin
        if (CW'(r_cap) > CW'(bmh_pkg::STORE_DEPTH - 1)) begin
            limit = CW'(bmh_pkg::STORE_DEPTH - 1);
        end else begin
            limit = CW'(r_cap);
        end
    end

    assign want_emit = (r_count > limit) || (r_end && (r_count != '0));
    assign emit_last = !(r_end && (r_count != CW'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmh_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_state = (r_count == '0) ? bmh_pkg::S_INS : bmh_pkg::S_CMP;
                end
            end
            bmh_pkg::S_CMP: begin
                if (!above) begin
                    n_state = bmh_pkg::S_POST;
                end else if (r_pos == AW'(1)) begin
                    n_state = bmh_pkg::S_INS;
                end
            end
            bmh_pkg::S_INS: begin
                n_state = bmh_pkg::S_POST;
            end
            bmh_pkg::S_POST: begin
                n_state = want_emit ? bmh_pkg::S_EMIT : bmh_pkg::S_IDLE;
            end
            bmh_pkg::S_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = bmh_pkg::S_IDLE;
                end
            end
            default: n_state = bmh_pkg::S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_new      = r_new;
        n_end      = r_end;
        n_pos      = r_pos;
        n_head     = r_head;
        n_count    = r_count;
        n_drain    = r_drain;
        n_m_data   = r_m_data;
        n_m_drain  = r_m_drain;
        n_m_last   = r_m_last;
        n_m_tvalid = i_m_tready ? 1'b0 : r_m_tvalid;
        mem_req    = '0;
        case (r_state)
            bmh_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_new.key       = i_s_tdata[63:0];
                    n_new.value     = i_s_tdata[127:64];
                    n_end           = i_s_tlast;
                    n_pos           = r_count[AW-1:0];
                    // fetch the back entry
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = AW'(r_head + r_count[AW-1:0] - AW'(1));
                end
            end
            bmh_pkg::S_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = AW'(r_head + r_pos);
                if (above) begin
                    // move the larger entry one place back, fetch the next one unless the front is reached
                    mem_req.wr_data = rd_data;
                    n_pos           = AW'(r_pos - AW'(1));
                    if (r_pos != AW'(1)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = AW'(r_head + r_pos - AW'(2));
                    end
                end else begin
                    mem_req.wr_data = r_new;
                    n_count         = CW'(r_count + CW'(1));
                end
            end
            bmh_pkg::S_INS: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = AW'(r_head + r_pos);
                mem_req.wr_data = r_new;
                n_count         = CW'(r_count + CW'(1));
            end
            bmh_pkg::S_POST: begin
                n_drain = !(r_count > limit);
                if (want_emit) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_head;
                end
            end
            bmh_pkg::S_EMIT: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_data   = rd_data;
                    n_m_drain  = r_drain;
                    n_m_last   = emit_last;
                    n_head     = AW'(r_head + AW'(1));
                    n_count    = CW'(r_count - CW'(1));
                    n_drain    = 1'b1;
                    if (!emit_last) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = AW'(r_head + AW'(1));
                    end
                end
            end
            default: begin
                n_m_tvalid = r_m_tvalid;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmh_pkg::S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= bmh_pkg::CAP_RESET;
            r_float <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmh_pkg::CFG_CAPACITY:  r_cap   <= i_cfg_data[bmh_pkg::CAP_W-1:0];
                bmh_pkg::CFG_KEY_FLOAT: r_float <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_new     <= n_new;
        r_end     <= n_end;
        r_pos     <= n_pos;
        r_drain   <= n_drain;
        r_m_data  <= n_m_data;
        r_m_drain <= n_m_drain;
        r_m_last  <= n_m_last;
    end

    // output transaction
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {r_m_data.value, r_m_data.key};
    assign o_m_tuser  = r_m_drain;
    assign o_m_tlast  = r_m_last;

endmodule
